// File: hdl/vibrating_gap_particle_step_unit_defines.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef VIBRATING_GAP_PARTICLE_STEP_UNIT_DEFINES_SVH
`define VIBRATING_GAP_PARTICLE_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define VGPS_ASSERT_NOW(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("vgps check failed");

// next-cycle implication
`define VGPS_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("vgps check failed");

`endif

// File: hdl/vgps_pkg.sv
// Types, register codes, reset values and saturation helper for the particle step unit.
// No dependencies.
package vgps_pkg;

    typedef struct packed {
        logic signed [31:0] height;
        logic signed [31:0] velocity;
        logic [30:0]        radius;
        logic               end_of_sweep;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_height;
        logic signed [31:0] new_velocity;
        logic [1:0]         contact;
        logic               sweep_done;
    } t_out;

    localparam logic [2:0] REG_AMPLITUDE   = 3'd0;
    localparam logic [2:0] REG_OMEGA       = 3'd1;
    localparam logic [2:0] REG_TIME_STEP   = 3'd2;
    localparam logic [2:0] REG_GAP_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_GRAVITY     = 3'd4;
    localparam logic [2:0] REG_RESTITUTION = 3'd5;
    localparam logic [2:0] REG_STIFFNESS   = 3'd6;
    localparam logic [2:0] REG_DAMPING     = 3'd7;

    localparam logic [1:0] CONTACT_NONE    = 2'd0;
    localparam logic [1:0] CONTACT_FLOOR   = 2'd1;
    localparam logic [1:0] CONTACT_CEILING = 2'd2;

    localparam logic [30:0]        RST_AMPLITUDE   = 31'd19005;
    localparam logic [30:0]        RST_OMEGA       = 31'd65536;
    localparam logic [30:0]        RST_TIME_STEP   = 31'd411;
    localparam logic [30:0]        RST_GAP_HEIGHT  = 31'd196608;
    localparam logic signed [31:0] RST_GRAVITY     = -32'sd6554;
    localparam logic [16:0]        RST_RESTITUTION = 17'd58982;
    localparam logic [30:0]        RST_STIFFNESS   = 31'd65601536;
    localparam logic [30:0]        RST_DAMPING     = 31'd65536;

    // 2^32 / (2 pi), rounded
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam longint      HALF_PI_Q30    = 64'sd1686629713;
    localparam longint      Q30_ONE        = 64'sd1073741824;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] res;
        if (x > 66'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (x < -66'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

// File: hdl/vibrating_gap_particle_step_unit.sv
// Particle step unit: plate position lookup, wall contact, free flight, 15-stage pipeline.
// Depends on vgps_pkg.
//
//  channel | dir | handshake                 | payload
//  in      | in  | i_in_valid / o_in_ready   | i_in  (vgps_pkg::t_in)
//  out     | out | o_out_valid / i_out_ready | o_out (vgps_pkg::t_out)
//  cfg     | in  | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One word per cycle in while the output is not stalled; each word leaves from the last stage.
// The plate phase is read in stage 4, in word order, and advanced there after each end-of-sweep word.
// A stalled output freezes every stage; o_in_ready is low only then.
// Reset (synchronous) clears valid bits and phase and loads the config registers' reset values; no clearing pass.
module vibrating_gap_particle_step_unit #(
    parameter int HARD_WALLS       = 1,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int FRACTION_BITS    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  vgps_pkg::t_in     i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output vgps_pkg::t_out    o_out,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);

    localparam int IW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MW    = FRACTION_BITS + 1;
    localparam int P1W   = 62 - FRACTION_BITS;
    localparam int NST   = 15;

    // (2n)(2n+1) for the Taylor terms n = 1..7
    localparam longint TAYLOR_DIV [1:7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                            64'sd110, 64'sd156, 64'sd210};

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] v;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic [30:0]        r;
        logic [IW-1:0]      idx;
        logic [1:0]         quad;
        logic [1:0]         contact;
        logic               last;
    } t_stage;

    function automatic longint sine_entry(input int i);
        longint x;
        longint term;
        longint sum;
        x    = (longint'(i) * vgps_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
        term = x;
        sum  = x;
        for (int n = 1; n <= 7; n++) begin
            term = (term * x) / vgps_pkg::Q30_ONE;
            term = (term * x) / vgps_pkg::Q30_ONE;
            term = -term / TAYLOR_DIV[n];
            sum  = sum + term;
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > vgps_pkg::Q30_ONE) begin
            sum = vgps_pkg::Q30_ONE;
        end
        return (sum + (longint'(1) << (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
    endfunction

    function automatic logic signed [65:0] ext(input logic signed [31:0] x);
        return {{34{x[31]}}, x};
    endfunction

    function automatic logic signed [32:0] s33(input logic signed [31:0] x);
        return {x[31], x};
    endfunction

    function automatic logic signed [32:0] u33(input logic [30:0] x);
        return {2'b00, x};
    endfunction

    // product, floored to the fraction grid, saturated
    function automatic logic signed [31:0] fmul(input logic signed [32:0] x,
                                                input logic signed [32:0] y);
        logic signed [65:0] p;
        p = 66'(x) * 66'(y);
        return vgps_pkg::sat32(p >>> FRACTION_BITS);
    endfunction

    logic [MW-1:0] w_sine_tab [0:SINE_TABLE_DEPTH];
    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
        assign w_sine_tab[g] = MW'(sine_entry(g));
    end

    // configuration
    logic [30:0]        r_amp, r_omega, r_ts, r_gap, r_stiff, r_damp;
    logic signed [31:0] r_grav;
    logic [16:0]        r_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp   <= vgps_pkg::RST_AMPLITUDE;
            r_omega <= vgps_pkg::RST_OMEGA;
            r_ts    <= vgps_pkg::RST_TIME_STEP;
            r_gap   <= vgps_pkg::RST_GAP_HEIGHT;
            r_grav  <= vgps_pkg::RST_GRAVITY;
            r_rest  <= vgps_pkg::RST_RESTITUTION;
            r_stiff <= vgps_pkg::RST_STIFFNESS;
            r_damp  <= vgps_pkg::RST_DAMPING;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vgps_pkg::REG_AMPLITUDE:   r_amp   <= i_cfg_data[30:0];
                vgps_pkg::REG_OMEGA:       r_omega <= i_cfg_data[30:0];
                vgps_pkg::REG_TIME_STEP:   r_ts    <= i_cfg_data[30:0];
                vgps_pkg::REG_GAP_HEIGHT:  r_gap   <= i_cfg_data[30:0];
                vgps_pkg::REG_GRAVITY:     r_grav  <= i_cfg_data;
                vgps_pkg::REG_RESTITUTION: r_rest  <= i_cfg_data[16:0];
                vgps_pkg::REG_STIFFNESS:   r_stiff <= i_cfg_data[30:0];
                vgps_pkg::REG_DAMPING:     r_damp  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // values that follow from the registers alone, computed through further registers after a write
    logic [61:0]        w_ot;
    logic [P1W-1:0]     r_p1;
    logic [63:0]        r_inc_hi, r_inc_lo;
    logic [31:0]        w_inc;
    logic signed [31:0] r_ao, r_gdt, r_gdt2;
    logic signed [31:0] w_half;

    assign w_ot   = 62'(r_omega) * 62'(r_ts);
    assign w_inc  = 32'((r_inc_hi << (24 - FRACTION_BITS)) + (r_inc_lo >> FRACTION_BITS));
    assign w_half = r_gdt2 >>> 1;

    always_ff @(posedge i_clk) begin
        r_p1     <= w_ot[61:FRACTION_BITS];
        r_inc_hi <= 64'(r_p1[P1W-1:24]) * 64'(vgps_pkg::INV_TWO_PI_Q32);
        r_inc_lo <= 64'(r_p1[23:0]) * 64'(vgps_pkg::INV_TWO_PI_Q32);
        r_ao     <= fmul(u33(r_amp), u33(r_omega));
        r_gdt    <= fmul(s33(r_grav), u33(r_ts));
        r_gdt2   <= fmul(s33(r_gdt), u33(r_ts));
    end

    // pipeline
    logic              w_en;
    logic [NST:1]      r_vld;
    t_stage            r_st [1:NST];
    t_stage            n_st [1:NST];
    logic [31:0]       r_phase;
    logic [42:0]       w_idx_prod;
    logic [IW-1:0]     w_addr_s, w_addr_c;
    logic signed [32:0] w_one_rest;

    assign w_en       = !r_vld[NST] || i_out_ready;
    assign o_in_ready = w_en;
    assign w_idx_prod = 43'(r_phase[29:0]) * 43'(SINE_TABLE_DEPTH);
    assign w_addr_s   = r_st[4].quad[0] ? IW'(SINE_TABLE_DEPTH) - r_st[4].idx : r_st[4].idx;
    assign w_addr_c   = r_st[4].quad[0] ? r_st[4].idx : IW'(SINE_TABLE_DEPTH) - r_st[4].idx;
    assign w_one_rest = (33'sd1 <<< FRACTION_BITS) + $signed({16'b0, r_rest});

    always_comb begin
        n_st[1].z       = i_in.height;
        n_st[1].v       = i_in.velocity;
        n_st[1].r       = i_in.radius;
        n_st[1].last    = i_in.end_of_sweep;
        n_st[1].a       = '0;
        n_st[1].b       = '0;
        n_st[1].c       = '0;
        n_st[1].idx     = '0;
        n_st[1].quad    = '0;
        n_st[1].contact = vgps_pkg::CONTACT_NONE;
        for (int k = 2; k <= NST; k++) begin
            n_st[k] = r_st[k-1];
        end

        // stage 4: table index from the current phase
        n_st[4].idx  = IW'(w_idx_prod >> 30);
        n_st[4].quad = r_phase[31:30];

        // stage 5: table read; quad now holds {cos negative, sin negative}
        n_st[5].a    = 32'(w_sine_tab[w_addr_s]);
        n_st[5].b    = 32'(w_sine_tab[w_addr_c]);
        n_st[5].quad = {r_st[4].quad[1] ^ r_st[4].quad[0], r_st[4].quad[1]};

        // stage 6: floor position, plate velocity
        n_st[6].a = fmul(u33(r_amp), r_st[5].quad[0] ? -s33(r_st[5].a) : s33(r_st[5].a));
        n_st[6].b = fmul(s33(r_ao), r_st[5].quad[1] ? -s33(r_st[5].b) : s33(r_st[5].b));

        // stage 7
        n_st[7].a = vgps_pkg::sat32(ext(r_st[6].a) + 66'(r_st[6].r));
        n_st[7].b = vgps_pkg::sat32(ext(r_st[6].a) + 66'(r_gap));
        n_st[7].c = vgps_pkg::sat32(ext(r_st[6].b) - ext(r_st[6].v));

        // stage 8: floor overlap, ceiling bound, restitution impulse
        n_st[8].a = vgps_pkg::sat32(ext(r_st[7].z) - ext(r_st[7].a));
        n_st[8].b = vgps_pkg::sat32(ext(r_st[7].b) - 66'(r_st[7].r));
        n_st[8].c = fmul(w_one_rest, s33(r_st[7].c));

        // stage 9: contact decision, floor first
        if (r_st[8].a < 0) begin
            n_st[9].contact = vgps_pkg::CONTACT_FLOOR;
            n_st[9].a       = r_st[8].a;
        end else begin
            n_st[9].a = vgps_pkg::sat32(ext(r_st[8].z) - ext(r_st[8].b));
            if (n_st[9].a > 0) begin
                n_st[9].contact = vgps_pkg::CONTACT_CEILING;
            end else begin
                n_st[9].contact = vgps_pkg::CONTACT_NONE;
            end
        end

        if (HARD_WALLS != 0) begin
            if (r_st[9].contact != vgps_pkg::CONTACT_NONE) begin
                n_st[10].z = vgps_pkg::sat32(ext(r_st[9].z) - (ext(r_st[9].a) <<< 1));
                n_st[10].v = vgps_pkg::sat32(ext(r_st[9].v) + ext(r_st[9].c));
            end
            n_st[11].a = fmul(s33(r_st[10].v), u33(r_ts));
            n_st[12].z = vgps_pkg::sat32(ext(r_st[11].z) + ext(w_half) + ext(r_st[11].a));
            n_st[12].v = vgps_pkg::sat32(ext(r_st[11].v) + ext(r_gdt));
        end else begin
            n_st[10].a = fmul(s33(r_st[9].a), u33(r_stiff));
            n_st[10].b = fmul(s33(r_st[9].v), u33(r_damp));
            if (r_st[10].contact != vgps_pkg::CONTACT_NONE) begin
                n_st[11].a = vgps_pkg::sat32(ext(r_grav) - ext(vgps_pkg::sat32(
                                 ext(r_st[10].a) + ext(r_st[10].b))));
            end else begin
                n_st[11].a = r_grav;
            end
            n_st[12].a = fmul(s33(r_st[11].a), u33(r_ts));
            n_st[13].v = vgps_pkg::sat32(ext(r_st[12].v) + ext(r_st[12].a));
            n_st[14].a = fmul(s33(r_st[13].v), u33(r_ts));
            n_st[15].z = vgps_pkg::sat32(ext(r_st[14].z) + ext(r_st[14].a));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_phase <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-1:1], i_in_valid};
            if (r_vld[3] && r_st[3].last) begin
                r_phase <= r_phase + w_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 1; k <= NST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_out_valid        = r_vld[NST];
    assign o_out.new_height   = r_st[NST].z;
    assign o_out.new_velocity = r_st[NST].v;
    assign o_out.contact      = r_st[NST].contact;
    assign o_out.sweep_done   = r_st[NST].last;

endmodule

// File: hdl/vgps_checker.sv
// Port-level checks for the particle step unit, bound to the top level.
// Depends on vgps_pkg and vibrating_gap_particle_step_unit_defines.svh.
`include "vibrating_gap_particle_step_unit_defines.svh"

module vgps_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input vgps_pkg::t_out o_out
);

    // a blocked output word stalls the input side
    `VGPS_ASSERT_NOW(a_stall_in, i_clk, !i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)

    // empty output stage never stalls
    `VGPS_ASSERT_NOW(a_ready_empty, i_clk, !i_rst_n, !o_out_valid, o_in_ready)

    `VGPS_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))

    `VGPS_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_out_valid)

endmodule

bind vibrating_gap_particle_step_unit vgps_checker u_vgps_checker (.*);
